@@ rtl/wavetable_voice_with_envelope_macros.svh @@
// Assertion helpers used by the checker of the voice.
`ifndef WAVETABLE_VOICE_WITH_ENVELOPE_MACROS_SVH
`define WAVETABLE_VOICE_WITH_ENVELOPE_MACROS_SVH

// The consequent is checked from the same edge as the antecedent.
`define WVENV_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent is checked in the cycle after the antecedent.
`define WVENV_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/wvenv_pkg.sv @@
package wvenv_pkg;

    localparam int PHASE_SHIFT = 22;
    localparam int TABLE_AW    = 10;
    localparam int TABLE_DEPTH = 1 << TABLE_AW;
    localparam int SAMPLE_W    = 16;
    localparam int VEL_W       = 7;
    localparam int TICKS_W     = 16;
    localparam int LEVEL_W     = 32;
    localparam int COUNT_W     = TICKS_W + 1;
    localparam int FADE_W      = 17;
    localparam int FMIX_W      = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int MUL_W       = 17;
    localparam int PROD_W      = 2 * MUL_W;
    localparam int MUL_CNT_W   = 5;
    localparam int DIV_W       = 34;
    localparam int DIV_CNT_W   = 6;
    localparam int PEAK_SHIFT  = 23;
    localparam int LEVEL_SHIFT = 16;
    localparam int AMP_SHIFT   = 15;

    localparam logic [COUNT_W-1:0] HOLD_TICKS = COUNT_W'(100);
    localparam logic [FADE_W-1:0]  FADE_STEP  = FADE_W'(10);
    localparam logic [FADE_W-1:0]  FADE_END   = FADE_W'(16'hFFFF);
    localparam logic [FMIX_W-1:0]  FMIX_FULL  = 8'hFF;

    typedef enum logic [1:0] {
        REQ_TICK    = 2'd0,
        REQ_NOTE_ON = 2'd1,
        REQ_RELEASE = 2'd2,
        REQ_LOAD    = 2'd3
    } req_type_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ATK_SOFT = 3'd0,
        CFG_ATK_HARD = 3'd1,
        CFG_RLS_SOFT = 3'd2,
        CFG_RLS_HARD = 3'd3,
        CFG_VOLUME   = 3'd4,
        CFG_SUS_FRAC = 3'd5
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ENV_ATTACK  = 2'd0,
        ENV_DECAY   = 2'd1,
        ENV_SUSTAIN = 2'd2,
        ENV_RELEASE = 2'd3
    } env_stage_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ATK_MUL,
        S_ATK_WAIT,
        S_RLS_MUL,
        S_RLS_WAIT,
        S_SUS_MUL,
        S_SUS_WAIT,
        S_RAMP,
        S_DIV_WAIT,
        S_ENV,
        S_MIX_MUL,
        S_MIX_WAIT,
        S_AMP_MUL,
        S_AMP_WAIT,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

endpackage

@@ rtl/wvenv_if.sv @@
interface wvenv_req_if;
    import wvenv_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [1:0]                 req_type;
    logic signed [SAMPLE_W-1:0] mix_in;
    logic [VEL_W-1:0]           velocity;
    logic [31:0]                phase_step;
    logic                       wave_select;
    logic [TABLE_AW-1:0]        wave_index;
    logic signed [SAMPLE_W-1:0] wave_value;

    modport source (output valid, req_type, mix_in, velocity, phase_step, wave_select,
                    wave_index, wave_value, input ready);
    modport sink (input valid, req_type, mix_in, velocity, phase_step, wave_select,
                  wave_index, wave_value, output ready);
endinterface

interface wvenv_res_if;
    import wvenv_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] mix_out;
    logic                       voice_done;

    modport source (output valid, mix_out, voice_done, input ready);
    modport sink (input valid, mix_out, voice_done, output ready);
endinterface

interface wvenv_cfg_if;
    import wvenv_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/wvenv_mul.sv @@
module wvenv_mul (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    start,
    input  logic signed [wvenv_pkg::MUL_W-1:0]      a,
    input  logic signed [wvenv_pkg::MUL_W-1:0]      b,
    output wvenv_pkg::unit_stat_t                   stat,
    output logic signed [wvenv_pkg::PROD_W-1:0]     prod
);
    import wvenv_pkg::*;

    // Shift-and-add over the bits of b, LSB first; the sign bit of b weighs negative.
    logic signed [PROD_W-1:0] acc_reg, acc_next;
    logic signed [PROD_W-1:0] a_sh_reg, a_sh_next;
    logic [MUL_W-1:0]         b_sh_reg, b_sh_next;
    logic [MUL_CNT_W-1:0]     cnt_reg, cnt_next;
    logic                     busy_reg, busy_next;
    logic                     done_reg, done_next;
    logic signed [PROD_W-1:0] addend;
    logic                     last;

    always_comb
    begin
        last      = (cnt_reg == MUL_CNT_W'(MUL_W - 1));
        addend    = last ? -a_sh_reg : a_sh_reg;
        acc_next  = acc_reg;
        a_sh_next = a_sh_reg;
        b_sh_next = b_sh_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            acc_next  = '0;
            a_sh_next = PROD_W'(a);
            b_sh_next = b;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (b_sh_reg[0])
            begin
                acc_next = acc_reg + addend;
            end
            a_sh_next = a_sh_reg <<< 1;
            b_sh_next = b_sh_reg >> 1;
            cnt_next  = cnt_reg + MUL_CNT_W'(1);
            if (last)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        a_sh_reg <= a_sh_next;
        b_sh_reg <= b_sh_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign prod      = acc_reg;

endmodule

@@ rtl/wvenv_div.sv @@
module wvenv_div (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    start,
    input  logic signed [wvenv_pkg::DIV_W-1:0]      dividend,
    input  logic [wvenv_pkg::COUNT_W-1:0]           divisor,
    output wvenv_pkg::unit_stat_t                   stat,
    output logic [wvenv_pkg::LEVEL_W-1:0]           quot
);
    import wvenv_pkg::*;

    // Restoring division of magnitudes, one quotient bit per cycle; the
    // quotient bits shift into the low end of the dividend register.
    logic [DIV_W-1:0]     work_reg, work_next;
    logic [COUNT_W-1:0]   rem_reg, rem_next;
    logic [COUNT_W-1:0]   dvs_reg, dvs_next;
    logic                 neg_reg, neg_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [COUNT_W:0]     trial;
    logic                 fits;
    logic [DIV_W-1:0]     qfull;

    always_comb
    begin
        trial     = {rem_reg, work_reg[DIV_W-1]};
        fits      = (trial >= {1'b0, dvs_reg});
        work_next = work_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            work_next = dividend[DIV_W-1] ? DIV_W'(-dividend) : DIV_W'(dividend);
            rem_next  = '0;
            dvs_next  = divisor;
            neg_next  = dividend[DIV_W-1];
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? COUNT_W'(trial - {1'b0, dvs_reg}) : COUNT_W'(trial);
            work_next = {work_reg[DIV_W-2:0], fits};
            cnt_next  = cnt_reg + DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(DIV_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        qfull = neg_reg ? (DIV_W'(0) - work_reg) : work_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
        neg_reg  <= neg_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quot      = qfull[LEVEL_W-1:0];

endmodule

@@ rtl/wvenv_wavemem.sv @@
module wvenv_wavemem (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic                                    wsel,
    input  logic [wvenv_pkg::TABLE_AW-1:0]          waddr,
    input  logic signed [wvenv_pkg::SAMPLE_W-1:0]   wdata,
    input  logic [wvenv_pkg::TABLE_AW-1:0]          raddr,
    output logic signed [wvenv_pkg::SAMPLE_W-1:0]   start_q,
    output logic signed [wvenv_pkg::SAMPLE_W-1:0]   end_q
);
    import wvenv_pkg::*;

    logic signed [SAMPLE_W-1:0] start_mem [TABLE_DEPTH];
    logic signed [SAMPLE_W-1:0] end_mem [TABLE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (we && !wsel)
        begin
            start_mem[waddr] <= wdata;
        end
        if (we && wsel)
        begin
            end_mem[waddr] <= wdata;
        end
        start_q <= start_mem[raddr];
        end_q   <= end_mem[raddr];
    end

endmodule

@@ rtl/wavetable_voice_with_envelope.sv @@
// One synthesizer voice: a wavetable oscillator with a linear envelope.
// The req channel carries one word per request: a tick, a note on, a release
// or a load of one wave table entry. Only a tick gives a res word: the incoming
// mix plus the scaled voice sample (the mix alone when done) and a done flag.
// The cfg channel writes the six envelope and level registers; it is always
// ready and should only be written while the voice is idle.
// Loads and releases are taken in the idle state and leave the voice ready.
// A tick on a playing voice steps the envelope in S_ENV, makes two passes of
// the bit-serial multiplier (17 shift steps each) and hands the word over to
// the output register in S_EMIT. The next word is accepted the cycle after.
// A tick that starts a decay or release of nonzero length also waits for the
// serial divider, one of zero length only passes through S_RAMP. A note on
// keeps the voice busy for three multiplier passes, and also for a divide
// when the attack is nonzero. A tick on an idle voice goes from the idle
// state straight to S_EMIT, and a tick that ends the release goes through
// S_ENV to S_EMIT.
// A finished result sits in an output register; the voice accepts the next
// word while it waits, and only a later result stalls until it is taken.
// Reset clears all voice state and leaves the voice idle with the registers
// at their defaults; the wave tables are not cleared and must be loaded.
module wavetable_voice_with_envelope (
    input  logic         clk,
    input  logic         rst_n,
    wvenv_req_if.sink    req,
    wvenv_res_if.source  res,
    wvenv_cfg_if.sink    cfg
);
    import wvenv_pkg::*;

    // Configuration registers.
    logic [TICKS_W-1:0] atk_soft_reg, atk_hard_reg, rls_soft_reg, rls_hard_reg;
    logic [VEL_W-1:0]   volume_reg, sus_frac_reg;

    // Voice state.
    state_t               state_reg, state_next;
    logic [LEVEL_W-1:0]   phase_reg, phase_next;
    logic [LEVEL_W-1:0]   phase_inc_reg, phase_inc_next;
    env_stage_t           env_stage_reg, env_stage_next;
    logic                 rel_req_reg, rel_req_next;
    logic [COUNT_W-1:0]   stage_cnt_reg, stage_cnt_next;
    logic [LEVEL_W-1:0]   step_reg, step_next;
    logic [LEVEL_W-1:0]   level_reg, level_next;
    logic [COUNT_W-1:0]   decay_reg, decay_next;
    logic [LEVEL_W-1:0]   sus_target_reg, sus_target_next;
    logic [TICKS_W-1:0]   release_reg, release_next;
    logic [FADE_W-1:0]    fade_reg, fade_next;
    logic                 active_reg, active_next;
    logic                 out_valid_reg, out_valid_next;

    // Working payload.
    logic                       tick_reg, tick_next;
    logic [VEL_W-1:0]           vel_reg, vel_next;
    logic signed [SAMPLE_W-1:0] mix_reg, mix_next;
    logic [LEVEL_W-1:0]         ramp_target_reg, ramp_target_next;
    logic [COUNT_W-1:0]         ramp_cnt_reg, ramp_cnt_next;
    logic signed [SAMPLE_W-1:0] sample_reg, sample_next;
    logic signed [SAMPLE_W-1:0] pend_mix_reg, pend_mix_next;
    logic                       pend_done_reg, pend_done_next;
    logic signed [SAMPLE_W-1:0] out_mix_reg, out_mix_next;
    logic                       out_done_reg, out_done_next;

    // Shared units.
    logic                     mul_start;
    logic signed [MUL_W-1:0]  mul_a, mul_b;
    unit_stat_t               mul_stat;
    logic signed [PROD_W-1:0] mul_prod;
    logic                     div_start;
    logic signed [DIV_W-1:0]  div_dividend;
    unit_stat_t               div_stat;
    logic [LEVEL_W-1:0]       div_quot;

    logic signed [SAMPLE_W-1:0] start_q, end_q;
    logic [TABLE_AW-1:0]        rd_addr;
    logic                       accept;
    logic [FMIX_W-1:0]          fmix;
    logic [LEVEL_W-1:0]         peak;
    logic [23:0]                blend;
    logic signed [25:0]         s0_ext, wave_sum;
    logic [LEVEL_W-1:0]         phase_sum;

    // Interpolated duration: base*127 + (hard - base)*vel, then divided by 128.
    function automatic logic [TICKS_W-1:0] lerp_ticks(input logic [TICKS_W-1:0] base_ticks,
                                                      input logic [23:0] prod_lo);
        logic [23:0] sum;
        sum = {1'b0, base_ticks, 7'b0} - {8'b0, base_ticks} + prod_lo;
        return sum[22:7];
    endfunction

    assign accept    = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;
    assign rd_addr   = TABLE_AW'(phase_reg >> PHASE_SHIFT);
    assign peak      = LEVEL_W'(volume_reg) << PEAK_SHIFT;
    assign fmix      = (fade_reg >= FADE_END) ? FMIX_FULL : fade_reg[15:8];
    assign phase_sum = phase_reg + phase_inc_reg;

    assign res.valid      = out_valid_reg;
    assign res.mix_out    = out_mix_reg;
    assign res.voice_done = out_done_reg;

    wvenv_wavemem u_mem (
        .clk     (clk),
        .we      (accept && (req.req_type == REQ_LOAD)),
        .wsel    (req.wave_select),
        .waddr   (req.wave_index),
        .wdata   (req.wave_value),
        .raddr   (rd_addr),
        .start_q (start_q),
        .end_q   (end_q)
    );

    wvenv_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .stat  (mul_stat),
        .prod  (mul_prod)
    );

    wvenv_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (ramp_cnt_reg),
        .stat     (div_stat),
        .quot     (div_quot)
    );

    // Configuration writes land directly in the registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            atk_soft_reg <= '0;
            atk_hard_reg <= '0;
            rls_soft_reg <= '0;
            rls_hard_reg <= '0;
            volume_reg   <= VEL_W'(127);
            sus_frac_reg <= VEL_W'(64);
        end
        else if (cfg.valid)
        begin
            case (cfg_reg_t'(cfg.index))
                CFG_ATK_SOFT: atk_soft_reg <= cfg.data;
                CFG_ATK_HARD: atk_hard_reg <= cfg.data;
                CFG_RLS_SOFT: rls_soft_reg <= cfg.data;
                CFG_RLS_HARD: rls_hard_reg <= cfg.data;
                CFG_VOLUME:   volume_reg   <= cfg.data[VEL_W-1:0];
                CFG_SUS_FRAC: sus_frac_reg <= cfg.data[VEL_W-1:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        phase_next       = phase_reg;
        phase_inc_next   = phase_inc_reg;
        env_stage_next   = env_stage_reg;
        rel_req_next     = rel_req_reg;
        stage_cnt_next   = stage_cnt_reg;
        step_next        = step_reg;
        level_next       = level_reg;
        decay_next       = decay_reg;
        sus_target_next  = sus_target_reg;
        release_next     = release_reg;
        fade_next        = fade_reg;
        active_next      = active_reg;
        tick_next        = tick_reg;
        vel_next         = vel_reg;
        mix_next         = mix_reg;
        ramp_target_next = ramp_target_reg;
        ramp_cnt_next    = ramp_cnt_reg;
        sample_next      = sample_reg;
        pend_mix_next    = pend_mix_reg;
        pend_done_next   = pend_done_reg;
        out_mix_next     = out_mix_reg;
        out_done_next    = out_done_reg;
        out_valid_next   = out_valid_reg && !res.ready;

        mul_start    = 1'b0;
        mul_a        = '0;
        mul_b        = '0;
        div_start    = 1'b0;
        div_dividend = $signed({2'b00, ramp_target_reg}) - $signed({{2{level_reg[31]}}, level_reg});

        blend    = mul_prod[23:0];
        s0_ext   = 26'(start_q);
        wave_sum = (s0_ext <<< 8) - s0_ext + mul_prod[25:0];

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (req_type_t'(req.req_type))
                        REQ_RELEASE:
                        begin
                            rel_req_next = 1'b1;
                        end
                        REQ_NOTE_ON:
                        begin
                            phase_inc_next = req.phase_step;
                            env_stage_next = ENV_ATTACK;
                            level_next     = '0;
                            rel_req_next   = 1'b0;
                            fade_next      = '0;
                            active_next    = 1'b1;
                            vel_next       = req.velocity;
                            tick_next      = 1'b0;
                            state_next     = S_ATK_MUL;
                        end
                        REQ_TICK:
                        begin
                            mix_next  = req.mix_in;
                            tick_next = 1'b1;
                            if (!active_reg)
                            begin
                                // An idle voice passes the mix through.
                                pend_mix_next  = req.mix_in;
                                pend_done_next = 1'b1;
                                state_next     = S_EMIT;
                            end
                            else
                            begin
                                phase_next = phase_sum;
                                if (fade_reg < FADE_END)
                                begin
                                    fade_next = fade_reg + FADE_STEP;
                                end
                                state_next = S_ENV;
                            end
                        end
                        default:
                        begin
                            // Table loads are written straight into the memory.
                        end
                    endcase
                end
            end

            S_ATK_MUL:
            begin
                mul_start  = 1'b1;
                mul_a      = $signed({1'b0, atk_hard_reg}) - $signed({1'b0, atk_soft_reg});
                mul_b      = $signed(MUL_W'(vel_reg));
                state_next = S_ATK_WAIT;
            end

            S_ATK_WAIT:
            begin
                if (mul_stat.done)
                begin
                    ramp_cnt_next = {1'b0, lerp_ticks(atk_soft_reg, blend)};
                    decay_next    = {lerp_ticks(atk_soft_reg, blend), 1'b0};
                    state_next    = S_RLS_MUL;
                end
            end

            S_RLS_MUL:
            begin
                mul_start  = 1'b1;
                mul_a      = $signed({1'b0, rls_hard_reg}) - $signed({1'b0, rls_soft_reg});
                mul_b      = $signed(MUL_W'(vel_reg));
                state_next = S_RLS_WAIT;
            end

            S_RLS_WAIT:
            begin
                if (mul_stat.done)
                begin
                    release_next = lerp_ticks(rls_soft_reg, blend);
                    state_next   = S_SUS_MUL;
                end
            end

            S_SUS_MUL:
            begin
                mul_start  = 1'b1;
                mul_a      = $signed(MUL_W'(volume_reg));
                mul_b      = $signed(MUL_W'(sus_frac_reg));
                state_next = S_SUS_WAIT;
            end

            S_SUS_WAIT:
            begin
                if (mul_stat.done)
                begin
                    // (peak / 128) * fraction is volume * fraction placed at bit 16.
                    sus_target_next  = {mul_prod[15:0], 16'b0};
                    ramp_target_next = peak;
                    state_next       = S_RAMP;
                end
            end

            S_RAMP:
            begin
                stage_cnt_next = ramp_cnt_reg;
                if (ramp_cnt_reg == '0)
                begin
                    // A stage of no length jumps straight to its target.
                    level_next = ramp_target_reg;
                    step_next  = '0;
                    state_next = tick_reg ? S_MIX_MUL : S_IDLE;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV_WAIT;
                end
            end

            S_DIV_WAIT:
            begin
                if (div_stat.done)
                begin
                    step_next  = div_quot;
                    state_next = tick_reg ? S_MIX_MUL : S_IDLE;
                end
            end

            S_ENV:
            begin
                state_next = S_MIX_MUL;
                if (stage_cnt_reg != '0)
                begin
                    stage_cnt_next = stage_cnt_reg - COUNT_W'(1);
                    level_next     = level_reg + step_reg;
                end
                else
                begin
                    case (env_stage_reg)
                        ENV_ATTACK:
                        begin
                            env_stage_next   = ENV_DECAY;
                            ramp_target_next = sus_target_reg;
                            ramp_cnt_next    = decay_reg;
                            state_next       = S_RAMP;
                        end
                        ENV_DECAY:
                        begin
                            env_stage_next = ENV_SUSTAIN;
                            stage_cnt_next = HOLD_TICKS;
                            step_next      = '0;
                        end
                        ENV_SUSTAIN:
                        begin
                            if (rel_req_reg)
                            begin
                                env_stage_next   = ENV_RELEASE;
                                ramp_target_next = '0;
                                ramp_cnt_next    = {1'b0, release_reg};
                                state_next       = S_RAMP;
                            end
                            else
                            begin
                                stage_cnt_next = HOLD_TICKS;
                            end
                        end
                        default:
                        begin
                            // The release has run out: the voice goes idle.
                            active_next    = 1'b0;
                            pend_mix_next  = mix_reg;
                            pend_done_next = 1'b1;
                            state_next     = S_EMIT;
                        end
                    endcase
                end
            end

            S_MIX_MUL:
            begin
                // s0*(255-f) + s1*f is computed as s0*255 + (s1-s0)*f.
                mul_start  = 1'b1;
                mul_a      = $signed({end_q[SAMPLE_W-1], end_q})
                           - $signed({start_q[SAMPLE_W-1], start_q});
                mul_b      = $signed(MUL_W'(fmix));
                state_next = S_MIX_WAIT;
            end

            S_MIX_WAIT:
            begin
                if (mul_stat.done)
                begin
                    sample_next = wave_sum[23:8];
                    state_next  = S_AMP_MUL;
                end
            end

            S_AMP_MUL:
            begin
                mul_start  = 1'b1;
                mul_a      = MUL_W'(sample_reg);
                mul_b      = MUL_W'($signed(level_reg[LEVEL_W-1:LEVEL_SHIFT]));
                state_next = S_AMP_WAIT;
            end

            S_AMP_WAIT:
            begin
                if (mul_stat.done)
                begin
                    pend_mix_next  = mix_reg + mul_prod[AMP_SHIFT+SAMPLE_W-1:AMP_SHIFT];
                    pend_done_next = 1'b0;
                    state_next     = S_EMIT;
                end
            end

            S_EMIT:
            begin
                if (!out_valid_reg || res.ready)
                begin
                    out_valid_next = 1'b1;
                    out_mix_next   = pend_mix_reg;
                    out_done_next  = pend_done_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            phase_reg      <= '0;
            phase_inc_reg  <= '0;
            env_stage_reg  <= ENV_ATTACK;
            rel_req_reg    <= 1'b0;
            stage_cnt_reg  <= '0;
            step_reg       <= '0;
            level_reg      <= '0;
            decay_reg      <= '0;
            sus_target_reg <= '0;
            release_reg    <= '0;
            fade_reg       <= '0;
            active_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            phase_inc_reg  <= phase_inc_next;
            env_stage_reg  <= env_stage_next;
            rel_req_reg    <= rel_req_next;
            stage_cnt_reg  <= stage_cnt_next;
            step_reg       <= step_next;
            level_reg      <= level_next;
            decay_reg      <= decay_next;
            sus_target_reg <= sus_target_next;
            release_reg    <= release_next;
            fade_reg       <= fade_next;
            active_reg     <= active_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tick_reg        <= tick_next;
        vel_reg         <= vel_next;
        mix_reg         <= mix_next;
        ramp_target_reg <= ramp_target_next;
        ramp_cnt_reg    <= ramp_cnt_next;
        sample_reg      <= sample_next;
        pend_mix_reg    <= pend_mix_next;
        pend_done_reg   <= pend_done_next;
        out_mix_reg     <= out_mix_next;
        out_done_reg    <= out_done_next;
    end

endmodule

@@ rtl/wvenv_checker.sv @@
`include "wavetable_voice_with_envelope_macros.svh"

module wvenv_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic [1:0]  req_type,
    input logic        res_valid,
    input logic        res_ready,
    input logic [15:0] mix_out,
    input logic        voice_done
);
    import wvenv_pkg::*;

    // A stalled result word keeps its value until it is taken.
    `WVENV_ASSERT_SAME(a_res_hold, res_valid && !res_ready, ##1 (res_valid && $stable(mix_out) && $stable(voice_done)), "result word changed while stalled")

    // A tick leaves the voice busy in the cycle after it is accepted.
    `WVENV_ASSERT_NEXT(a_tick_busy, req_valid && req_ready && req_type == REQ_TICK, !req_ready, "voice ready right after a tick")

    // Requests other than ticks bring up no result word right after they are accepted.
    `WVENV_ASSERT_NEXT(a_no_spurious, req_valid && req_ready && req_type != REQ_TICK, !$rose(res_valid), "result word after a non-tick request")

endmodule

bind wavetable_voice_with_envelope wvenv_checker u_wvenv_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .req_type   (req.req_type),
    .res_valid  (res.valid),
    .res_ready  (res.ready),
    .mix_out    (res.mix_out),
    .voice_done (res.voice_done)
);
